@@ rtl/core/pts_pkg.sv @@
// Shared types and constants for the pattern-triggered send scheduler.
// Used by pts_match, pts_sched and pattern_triggered_send_scheduler_top.
`default_nettype none

package pts_pkg;

	// Default sizes handed to the top level parameters
	localparam int PATTERN_BYTES_DEF = 8;
	localparam int COUNT_BITS_DEF    = 16;

	// Configuration port geometry
	localparam int CFG_INDEX_BITS = 3;
	localparam int CFG_DATA_BITS  = 64;

	// Register reset values
	localparam logic [63:0] PATTERN_RST  = 64'h0;
	localparam logic [3:0]  LENGTH_RST   = 4'd1;
	localparam logic [15:0] DELAY_RST    = 16'd0;
	localparam logic [15:0] PERIOD_RST   = 16'd0;
	localparam logic        PERIODIC_RST = 1'b0;
	localparam logic [1:0]  TRIGGER_RST  = 2'd0;

	// Item operation codes
	typedef enum logic [1:0] {
		OP_BYTE  = 2'd0,
		OP_TICK  = 2'd1,
		OP_START = 2'd2,
		OP_STOP  = 2'd3
	} op_t;

	// Trigger modes; the unused code does nothing on a tick
	typedef enum logic [1:0] {
		TRIG_MANUAL     = 2'd0,
		TRIG_READ       = 2'd1,
		TRIG_CONTINUOUS = 2'd2,
		TRIG_UNUSED     = 2'd3
	} trig_mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_PATTERN  = 3'd0,
		REG_LENGTH   = 3'd1,
		REG_DELAY    = 3'd2,
		REG_PERIOD   = 3'd3,
		REG_PERIODIC = 3'd4,
		REG_TRIGGER  = 3'd5
	} cfg_reg_t;

	// Input item
	typedef struct packed {
		logic [1:0] operation;
		logic [7:0] rx_byte;
	} in_t;

	// Result item
	typedef struct packed {
		logic [15:0] send_count;
		logic        is_active;
	} out_t;

	// Scheduler settings
	typedef struct packed {
		logic [15:0] delay_ticks;
		logic [15:0] period_ticks;
		logic        periodic_mode;
		logic [1:0]  trigger_mode;
	} sched_cfg_t;

	// Scheduler timing state
	typedef struct packed {
		logic        running;
		logic [15:0] delay_left;
		logic [15:0] period_left;
	} sched_state_t;

	// Side effects of the scheduler on the matcher state
	typedef struct packed {
		logic clear_match;
		logic clear_trig;
	} sched_ctl_t;

endpackage

`default_nettype wire

@@ rtl/core/pattern_triggered_send_scheduler_top.sv @@
// Top level of the pattern-triggered send scheduler: config registers,
// input stage, state registers and result register. Depends on pts_pkg,
// pts_match and pts_sched.
//
//   port group   direction   transfer when           payload
//   in_*         to block    in_valid & !in_stall    in_data (operation, rx_byte)
//   out_*        from block  out_valid & !out_stall  out_data (send_count, is_active)
//   cfg_*        to block    cfg_write               cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; each result reaches
// out_data through the input stage and the result register (the input stage
// holds the item, then matcher and scheduler load result and state registers).
// arst_n clears all state: passive, match position and trigger count zero.
// out_stall holds the result register; in_stall rises only when both
// stages are full and the result is not taken.
`default_nettype none

module pattern_triggered_send_scheduler_top #(
	parameter int PATTERN_BYTES = pts_pkg::PATTERN_BYTES_DEF,
	parameter int COUNT_BITS    = pts_pkg::COUNT_BITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire pts_pkg::in_t                      in_data,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output pts_pkg::out_t                          out_data,
	input  wire logic                              cfg_write,
	input  wire logic [pts_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [pts_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
	import pts_pkg::*;

	// configuration registers
	logic [63:0] pattern_q;
	logic [3:0]  length_q;
	sched_cfg_t  sched_cfg_q;

	// pipeline and state
	in_t                   item_s1;
	logic                  valid_s1;
	out_t                  out_q;
	logic                  out_valid_q;
	logic [2:0]            match_pos_q;
	logic [COUNT_BITS-1:0] trig_q;
	sched_state_t          sched_q;

	logic                  out_free;
	logic                  advance;
	logic                  accept;
	logic [2:0]            match_pos_next;
	logic [COUNT_BITS-1:0] match_trig_next;
	sched_state_t          sched_next;
	sched_ctl_t            sched_ctl;
	logic [15:0]           send_count;
	logic [2:0]            pos_next;
	logic [COUNT_BITS-1:0] trig_next;

	// Handshake control
	assign out_free  = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_free;
	assign in_stall  = valid_s1 && !out_free;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Store configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q                 <= PATTERN_RST;
			length_q                  <= LENGTH_RST;
			sched_cfg_q.delay_ticks   <= DELAY_RST;
			sched_cfg_q.period_ticks  <= PERIOD_RST;
			sched_cfg_q.periodic_mode <= PERIODIC_RST;
			sched_cfg_q.trigger_mode  <= TRIGGER_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_PATTERN:  pattern_q                 <= cfg_data[63:0];
				REG_LENGTH:   length_q                  <= cfg_data[3:0];
				REG_DELAY:    sched_cfg_q.delay_ticks   <= cfg_data[15:0];
				REG_PERIOD:   sched_cfg_q.period_ticks  <= cfg_data[15:0];
				REG_PERIODIC: sched_cfg_q.periodic_mode <= cfg_data[0];
				REG_TRIGGER:  sched_cfg_q.trigger_mode  <= cfg_data[1:0];
				default: begin
				end
			endcase
		end
	end

	// Input stage: capture a transfer, drop it once it moves on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_data;
		end
	end

	pts_match #(
		.PATTERN_BYTES(PATTERN_BYTES),
		.COUNT_BITS   (COUNT_BITS)
	) u_match (
		.pattern  (pattern_q),
		.length   (length_q),
		.pos      (match_pos_q),
		.rx_byte  (item_s1.rx_byte),
		.trig     (trig_q),
		.pos_next (match_pos_next),
		.trig_next(match_trig_next)
	);

	pts_sched #(
		.COUNT_BITS(COUNT_BITS)
	) u_sched (
		.op        (item_s1.operation),
		.cfg       (sched_cfg_q),
		.state     (sched_q),
		.trig      (trig_q),
		.state_next(sched_next),
		.ctl       (sched_ctl),
		.send_count(send_count)
	);

	// Merge matcher and scheduler updates
	always_comb begin
		if (item_s1.operation == OP_BYTE) begin
			pos_next  = match_pos_next;
			trig_next = match_trig_next;
		end else begin
			pos_next  = sched_ctl.clear_match ? 3'd0 : match_pos_q;
			trig_next = sched_ctl.clear_trig ? '0 : trig_q;
		end
	end

	// State registers advance with the item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_pos_q <= 3'd0;
			trig_q      <= '0;
			sched_q     <= '0;
		end else if (advance) begin
			match_pos_q <= pos_next;
			trig_q      <= trig_next;
			sched_q     <= sched_next;
		end
	end

	// Result register: load on advance, clear valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.send_count <= send_count;
			out_q.is_active  <= sched_next.running;
		end
	end

	// Only ticks produce sends
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.operation != OP_TICK |=> out_q.send_count == 16'd0)
		else $error("send count on an item that is not a tick");

	// Start and stop leave the matcher cleared
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && (item_s1.operation == OP_START || item_s1.operation == OP_STOP)
		|=> match_pos_q == 3'd0 && trig_q == '0)
		else $error("matcher state not cleared by start or stop");

	// Stop always reports passive
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.operation == OP_STOP |=> !out_q.is_active && !sched_q.running)
		else $error("still active after stop");

	// A tick while passive leaves the counters alone
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && item_s1.operation == OP_TICK && !sched_q.running
		|=> $stable(sched_q) && out_q.send_count == 16'd0)
		else $error("passive tick changed the scheduler");

	// Input backpressure only with both stages full
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

@@ rtl/core/pts_match.sv @@
// Pattern matcher: next match position and saturating trigger count for one byte.
// Depends on pts_pkg.
`default_nettype none

module pts_match #(
	parameter int PATTERN_BYTES = pts_pkg::PATTERN_BYTES_DEF,
	parameter int COUNT_BITS    = pts_pkg::COUNT_BITS_DEF
) (
	input  wire logic [63:0]           pattern,
	input  wire logic [3:0]            length,
	input  wire logic [2:0]            pos,
	input  wire logic [7:0]            rx_byte,
	input  wire logic [COUNT_BITS-1:0] trig,
	output logic      [2:0]            pos_next,
	output logic      [COUNT_BITS-1:0] trig_next
);
	import pts_pkg::*;

	localparam logic [3:0] MaxLen = 4'(PATTERN_BYTES);

	logic [3:0] len_eff;
	logic [2:0] pos_eff;
	logic [3:0] pos_inc;
	logic [7:0] pat_byte;

	// Clamp length, restart a stale position, compare one byte
	always_comb begin
		if (length == 4'd0) begin
			len_eff = 4'd1;
		end else if (length > MaxLen) begin
			len_eff = MaxLen;
		end else begin
			len_eff = length;
		end
		pos_eff   = ({1'b0, pos} >= len_eff) ? 3'd0 : pos;
		pat_byte  = pattern[{pos_eff, 3'b000} +: 8];
		pos_inc   = {1'b0, pos_eff} + 4'd1;
		pos_next  = 3'd0;
		trig_next = trig;
		if (pat_byte == rx_byte) begin
			if (pos_inc >= len_eff) begin
				// full match: count it, saturating
				if (trig != '1) begin
					trig_next = trig + COUNT_BITS'(1);
				end
			end else begin
				pos_next = pos_inc[2:0];
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/pts_sched.sv @@
// Send scheduler: start, stop and tick handling with delay and period counters.
// Depends on pts_pkg.
`default_nettype none

module pts_sched #(
	parameter int COUNT_BITS = pts_pkg::COUNT_BITS_DEF
) (
	input  wire logic [1:0]            op,
	input  wire pts_pkg::sched_cfg_t   cfg,
	input  wire pts_pkg::sched_state_t state,
	input  wire logic [COUNT_BITS-1:0] trig,
	output pts_pkg::sched_state_t      state_next,
	output pts_pkg::sched_ctl_t        ctl,
	output logic      [15:0]           send_count
);
	import pts_pkg::*;

	logic        trig_any;
	logic [31:0] trig_wide;
	logic [15:0] trig_send;
	logic        delay_done;
	logic        period_done;
	logic [15:0] delay_dec;
	logic [15:0] period_dec;
	logic        armed;

	// Counter steps: decrement saturating at zero, done when at one or zero
	always_comb begin
		trig_any    = |trig;
		trig_wide   = 32'(trig);
		trig_send   = (trig_wide > 32'h0000_FFFF) ? 16'hFFFF : trig_wide[15:0];
		delay_done  = state.delay_left <= 16'd1;
		period_done = state.period_left <= 16'd1;
		delay_dec   = (state.delay_left == 16'd0) ? 16'd0 : state.delay_left - 16'd1;
		period_dec  = (state.period_left == 16'd0) ? 16'd0 : state.period_left - 16'd1;
		armed       = (cfg.trigger_mode == TRIG_MANUAL) || trig_any;
	end

	// Apply the operation
	always_comb begin
		state_next = state;
		ctl        = '0;
		send_count = 16'd0;
		case (op_t'(op))
			OP_START: begin
				state_next.running     = 1'b1;
				state_next.delay_left  = cfg.delay_ticks;
				state_next.period_left = 16'd0;
				ctl.clear_match        = 1'b1;
				ctl.clear_trig         = 1'b1;
			end
			OP_STOP: begin
				state_next.running = 1'b0;
				ctl.clear_match    = 1'b1;
				ctl.clear_trig     = 1'b1;
			end
			OP_TICK: begin
				if (state.running && !cfg.periodic_mode) begin
					case (cfg.trigger_mode)
						TRIG_MANUAL, TRIG_READ: begin
							if (cfg.trigger_mode == TRIG_MANUAL || trig_any) begin
								state_next.delay_left = delay_dec;
								if (delay_done) begin
									// single send, then drop back to passive
									send_count         = 16'd1;
									state_next.running = 1'b0;
									ctl.clear_match    = 1'b1;
									ctl.clear_trig     = 1'b1;
								end
							end
						end
						TRIG_CONTINUOUS: begin
							if (trig_any) begin
								state_next.delay_left = delay_dec;
								if (delay_done) begin
									// send every pending trigger and consume them
									send_count     = trig_send;
									ctl.clear_trig = 1'b1;
								end
							end
						end
						default: begin
						end
					endcase
				end else if (state.running && cfg.trigger_mode != TRIG_UNUSED && armed) begin
					// periodic: delay first, then the period counter
					state_next.delay_left = delay_dec;
					if (delay_done) begin
						state_next.period_left = period_dec;
						if (period_done) begin
							send_count             = 16'd1;
							state_next.period_left = cfg.period_ticks;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for pattern_triggered_send_scheduler_top: streams items and register writes,
// predicts every result with a local scheduler model and checks each transfer.
// Depends on pts_pkg and the scheduler RTL.

module tb_top;
	import pts_pkg::*;

	localparam int LATENCY = 2;
	localparam int SETTLE_CYCLES = LATENCY + 4;
	localparam int STUCK_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;
	localparam int RANDOM_PHASES = 10;
	localparam int CALM_PHASES = 2;
	localparam int PHASE_ITEMS = 30;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_data;
	logic cfg_write = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	pattern_triggered_send_scheduler_top u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Local copy of the registers
	logic [63:0] pat_bytes = PATTERN_RST;
	logic [3:0] pat_len = LENGTH_RST;
	logic [15:0] dly_cfg = DELAY_RST;
	logic [15:0] per_cfg = PERIOD_RST;
	logic repeat_cfg = PERIODIC_RST;
	logic [1:0] mode_cfg = TRIGGER_RST;

	// Local copy of the scheduler state
	logic [2:0] pat_pos = '0;
	logic [15:0] hit_count = '0;
	logic [15:0] wait_left = '0;
	logic [15:0] gap_left = '0;
	logic active = 1'b0;

	in_t item_backlog[$];
	out_t due_results[$];
	out_t want;

	int in_odds = 0;
	int out_odds = 0;
	int in_gap = 0;
	int out_gap = 0;
	int hold_left = 0;
	bit hold_req = 1'b0;
	bit in_moved = 1'b0;
	int fails = 0;
	int stuck = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	// Clamp the length register to the usable range
	function automatic int eff_length(input logic [3:0] len);
		if (len == 0) return 1;
		if (len > PATTERN_BYTES_DEF) return PATTERN_BYTES_DEF;
		return len;
	endfunction

	// Advance the scheduler model by one item and return its result
	function automatic out_t sched_predict(input in_t item);
		out_t res;
		int len;
		int p;
		bit wait_done;
		bit gap_done;
		res = '0;
		case (op_t'(item.operation))
			OP_BYTE: begin
				len = eff_length(pat_len);
				p = (pat_pos >= len) ? 0 : pat_pos;
				if (pat_bytes[8*p +: 8] == item.rx_byte) begin
					p++;
					if (p >= len) begin
						if (hit_count != 16'hFFFF) hit_count++;
						p = 0;
					end
				end else begin
					p = 0;
				end
				pat_pos = p[2:0];
			end
			OP_TICK: begin
				if (active && !repeat_cfg) begin
					if (mode_cfg == TRIG_MANUAL ||
					    ((mode_cfg == TRIG_READ || mode_cfg == TRIG_CONTINUOUS) &&
					     hit_count != 0)) begin
						wait_done = (wait_left <= 1);
						if (wait_left != 0) wait_left--;
						if (wait_done) begin
							wait_left = 0;
							if (mode_cfg == TRIG_CONTINUOUS) begin
								res.send_count = hit_count;
								hit_count = 0;
							end else begin
								res.send_count = 1;
								active = 1'b0;
								pat_pos = 0;
								hit_count = 0;
							end
						end
					end
				end else if (active && mode_cfg != TRIG_UNUSED &&
				             (mode_cfg == TRIG_MANUAL || hit_count != 0)) begin
					// periodic: delay first, then the period counter
					wait_done = (wait_left <= 1);
					if (wait_left != 0) wait_left--;
					if (wait_done) begin
						gap_done = (gap_left <= 1);
						if (gap_left != 0) gap_left--;
						if (gap_done) begin
							res.send_count = 1;
							wait_left = 0;
							gap_left = per_cfg;
						end
					end
				end
			end
			OP_START: begin
				active = 1'b1;
				gap_left = 0;
				wait_left = dly_cfg;
				pat_pos = 0;
				hit_count = 0;
			end
			OP_STOP: begin
				active = 1'b0;
				pat_pos = 0;
				hit_count = 0;
			end
			default: ;
		endcase
		res.is_active = active;
		return res;
	endfunction

	// Mostly short counts so that sends happen, sometimes the far end
	function automatic logic [15:0] rand_ticks();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 7) return 16'($urandom_range(0, 3));
		if (pick < 9) return 16'($urandom_range(4, 20));
		if ($urandom_range(0, 1) == 0) return 16'hFFFF;
		return 16'($urandom());
	endfunction

	task automatic push_item(input op_t op, input logic [7:0] b);
		in_t it;
		it.operation = op;
		it.rx_byte = b;
		item_backlog.push_back(it);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [63:0] v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_PATTERN: pat_bytes = v;
			REG_LENGTH: pat_len = v[3:0];
			REG_DELAY: dly_cfg = v[15:0];
			REG_PERIOD: per_cfg = v[15:0];
			REG_PERIODIC: repeat_cfg = v[0];
			REG_TRIGGER: mode_cfg = v[1:0];
			default: ;
		endcase
	endtask

	// Write every register, then drop the write enable
	task automatic set_all(input logic [63:0] pat, input logic [3:0] len,
	                       input logic [15:0] dly, input logic [15:0] per,
	                       input logic rep, input logic [1:0] mode);
		write_reg(REG_PATTERN, pat);
		write_reg(REG_LENGTH, 64'(len));
		write_reg(REG_DELAY, 64'(dly));
		write_reg(REG_PERIOD, 64'(per));
		write_reg(REG_PERIODIC, 64'(rep));
		write_reg(REG_TRIGGER, 64'(mode));
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// Wait for every item to go in and every result to come out
	task automatic settle();
		while (item_backlog.size() != 0 || in_valid || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Predict on each input transfer, check each output transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				due_results.push_back(sched_predict(in_data));
				in_moved = 1'b1;
			end
			if (out_valid && !out_stall) begin
				if (due_results.size() == 0) begin
					$error("unexpected result: send_count %0d is_active %0d",
					       out_data.send_count, out_data.is_active);
					fails++;
				end else begin
					want = due_results.pop_front();
					if (out_data.send_count !== want.send_count) begin
						$error("send_count: expected %0d, got %0d",
						       want.send_count, out_data.send_count);
						fails++;
					end
					if (out_data.is_active !== want.is_active) begin
						$error("is_active: expected %0d, got %0d",
						       want.is_active, out_data.is_active);
						fails++;
					end
				end
			end
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
			stuck = 0;
		else
			stuck++;
		if (stuck >= STUCK_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Sender: hold a stalled item, otherwise offer the next one or idle a burst
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_moved)) begin
			in_moved = 1'b0;
			if (in_gap > 0) begin
				in_valid <= 1'b0;
				in_gap--;
			end else if (item_backlog.size() != 0 && $urandom_range(0, 99) < in_odds) begin
				in_gap = $urandom_range(0, 11);
				in_valid <= 1'b0;
			end else if (item_backlog.size() != 0) begin
				in_data <= item_backlog.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: long hold on request, random stall bursts otherwise
	always @(negedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req = 1'b0;
		end
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (out_gap > 0) begin
			out_stall <= 1'b1;
			out_gap--;
		end else if ($urandom_range(0, 99) < out_odds) begin
			out_gap = $urandom_range(0, 11);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	initial begin : stimulus
		int n;
		int len;
		int pick;
		logic [7:0] b;
		logic [1:0] mode;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: passive tick, match on byte zero, manual one-shot
		push_item(OP_TICK, 8'h00);
		push_item(OP_BYTE, 8'h00);
		push_item(OP_START, 8'hFF);
		push_item(OP_TICK, 8'h00);
		push_item(OP_TICK, 8'h00);
		settle();

		// Oversized length acts as eight bytes; leave the match half done
		set_all(64'h01FE_807F_00FF_55AA, 4'd15, 16'd2, 16'd0, 1'b0, TRIG_READ);
		push_item(OP_START, 8'h00);
		push_item(OP_BYTE, 8'hAA);
		push_item(OP_BYTE, 8'h55);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_BYTE, 8'h00);
		settle();

		// Shrink the length below the stale position, then finish a match
		set_all(64'h01FE_807F_00FF_55AA, 4'd3, 16'd2, 16'd0, 1'b0, TRIG_READ);
		push_item(OP_BYTE, 8'h55);
		push_item(OP_BYTE, 8'hAA);
		push_item(OP_BYTE, 8'h55);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_TICK, 8'h00);
		push_item(OP_TICK, 8'h00);
		settle();

		// Zero length acts as one byte; continuous mode sends the whole count
		set_all(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 16'd0, 16'hFFFF, 1'b0, TRIG_CONTINUOUS);
		push_item(OP_START, 8'h00);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_BYTE, 8'hFF);
		push_item(OP_TICK, 8'h00);
		push_item(OP_TICK, 8'h00);
		settle();

		// Periodic manual: delay, then period reloads
		set_all(64'h0, 4'd8, 16'd1, 16'd2, 1'b1, TRIG_MANUAL);
		push_item(OP_START, 8'h00);
		push_item(OP_TICK, 8'h00);
		push_item(OP_TICK, 8'h00);
		push_item(OP_TICK, 8'h00);
		settle();

		// Unused trigger mode with both counters at their top
		set_all(64'h0, 4'd1, 16'hFFFF, 16'hFFFF, 1'b1, TRIG_UNUSED);
		push_item(OP_START, 8'h00);
		push_item(OP_TICK, 8'h00);
		push_item(OP_STOP, 8'h00);
		settle();

		// Random phases; the last ones run without idling
		for (int r = 0; r < RANDOM_PHASES + CALM_PHASES; r++) begin
			if (r >= RANDOM_PHASES) begin
				in_odds = 0;
				out_odds = 0;
			end else begin
				pick = $urandom_range(0, 2);
				in_odds = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
				pick = $urandom_range(0, 2);
				out_odds = (pick == 0) ? 0 : (pick == 1) ? 5 : 25;
			end
			mode = ($urandom_range(0, 9) == 0) ? TRIG_UNUSED : 2'($urandom_range(0, 2));
			set_all({$urandom(), $urandom()},
			        ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 3))
			                                   : 4'($urandom_range(0, 15)),
			        rand_ticks(), rand_ticks(), 1'($urandom_range(0, 1)), mode);

			// Back up the block: long receiver hold with the sender at full rate
			if (r == 3) begin
				in_odds = 0;
				hold_req = 1'b1;
			end

			if ($urandom_range(0, 4) != 0) push_item(OP_START, 8'($urandom()));
			n = 0;
			while (n < PHASE_ITEMS) begin
				pick = $urandom_range(0, 99);
				if (pick < 30) begin
					// pattern run, sometimes broken in its last byte
					len = eff_length(pat_len);
					for (int k = 0; k < len; k++) begin
						b = pat_bytes[8*k +: 8];
						if (k == len - 1 && $urandom_range(0, 6) == 0)
							b ^= 8'(1 << $urandom_range(0, 7));
						push_item(OP_BYTE, b);
					end
					n += len;
				end else begin
					if (pick < 62) push_item(OP_TICK, 8'($urandom()));
					else if (pick < 72) push_item(OP_START, 8'($urandom()));
					else if (pick < 77) push_item(OP_STOP, 8'($urandom()));
					else push_item(OP_BYTE, 8'($urandom_range(0, 255)));
					n++;
				end
			end
			settle();
		end

		if (fails == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
